[rtl/nnis_pkg.sv]
// Shared constants, register indexes and types of the nearest-neighbor scaler.
package nnis_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_SCALE  = 100;

  localparam int DIM_W      = 9;
  localparam int OUT_DIM_W  = 15;
  localparam int STEP_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PAD_W      = 2;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int LOAD_CNT_W  = STORE_AW + 1;
  localparam int X_W         = $clog2(MAX_WIDTH);
  localparam int Y_W         = $clog2(MAX_HEIGHT);
  localparam int MAX_OUT_W   = MAX_SCALE * MAX_WIDTH;
  localparam int MAX_OUT_H   = MAX_SCALE * MAX_HEIGHT;
  localparam int PROD_W      = OUT_DIM_W + STEP_W;
  localparam int COORD_W     = PROD_W - FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Q16   = 3'd4;

  localparam logic [STEP_W-1:0] STEP_RESET = 32'h0001_0000;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } nnis_pix_t;

  typedef struct packed {
    logic [DIM_W-1:0]  iw;
    logic [DIM_W-1:0]  ih;
    logic [STEP_W-1:0] step;
  } nnis_geom_t;

endpackage

[rtl/nnis_if.sv]
// Valid/ready channel interfaces for source pixels and scaled pixels.
interface nnis_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, cmd, blue_in, green_in, red_in, input ready);
  modport sink (input valid, cmd, blue_in, green_in, red_in, output ready);
endinterface

interface nnis_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [1:0] pad_bytes;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, blue_out, green_out, red_out, pad_bytes, row_end,
                  frame_end, input ready);
  modport sink (input valid, blue_out, green_out, red_out, pad_bytes, row_end,
                frame_end, output ready);
endinterface

[rtl/nearest_neighbor_image_scaler_core.sv]
// Top level of the nearest-neighbor image scaler: control, registers, output stage.
//
//   channel  | direction | payload                                        | transfer
//   in_pix   | in        | cmd, blue_in, green_in, red_in                 | valid & ready
//   out_pix  | out       | blue/green/red_out, pad_bytes, row_end, frame_end | valid & ready
//   cfg_*    | in        | cfg_index, cfg_wdata                           | cfg_we
//
// A load, or any command that yields no pixel, completes in S_IDLE without leaving it.
// A fetch runs through accept, multiply, clamp, store read and output register load in order;
// one fetch is in flight at a time, and its pixel shows once the output register is loaded.
// rst_n is synchronous; the frame store is not cleared and holds garbage until loaded.
// A stalled output holds the fetch in its last step; loads are not taken meanwhile.
module nearest_neighbor_image_scaler_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  nnis_in_if.sink                              in_pix,
  nnis_out_if.source                           out_pix,
  input  logic                                 cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int DIM_W     = nnis_pkg::DIM_W;
  localparam int OUT_DIM_W = nnis_pkg::OUT_DIM_W;
  localparam int STEP_W    = nnis_pkg::STEP_W;
  localparam int LC_W      = nnis_pkg::LOAD_CNT_W;
  localparam int TOT_W     = 2 * DIM_W;
  localparam int PAD_W     = nnis_pkg::PAD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // configuration
  logic [DIM_W-1:0]     in_width_r;
  logic [DIM_W-1:0]     in_height_r;
  logic [OUT_DIM_W-1:0] out_width_r;
  logic [OUT_DIM_W-1:0] out_height_r;
  logic [STEP_W-1:0]    step_r;

  // control
  logic [2:0]           state_r, state_nxt;
  logic                 phase_r, phase_nxt;
  logic [LC_W-1:0]      load_cnt_r, load_cnt_nxt;
  logic [OUT_DIM_W-1:0] out_col_r, out_col_nxt;
  logic [OUT_DIM_W-1:0] out_row_r, out_row_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // fetch payload in flight
  logic [OUT_DIM_W-1:0] pos_col_r, pos_col_nxt;
  logic [OUT_DIM_W-1:0] pos_row_r, pos_row_nxt;
  logic                 row_last_r, row_last_nxt;
  logic                 frame_last_r, frame_last_nxt;
  logic                 empty_src_r, empty_src_nxt;
  logic [PAD_W-1:0]     pad_r, pad_nxt;

  // output stage
  nnis_pkg::nnis_pix_t  opix_r, opix_nxt;
  logic [PAD_W-1:0]     opad_r, opad_nxt;
  logic                 orow_end_r, orow_end_nxt;
  logic                 oframe_end_r, oframe_end_nxt;

  logic [DIM_W-1:0]     iw_eff;
  logic [DIM_W-1:0]     ih_eff;
  logic [OUT_DIM_W-1:0] ow_eff;
  logic [OUT_DIM_W-1:0] oh_eff;
  logic [TOT_W-1:0]     total;
  logic [LC_W-1:0]      lc_tmp;
  logic [OUT_DIM_W:0]   col_p1;
  logic [OUT_DIM_W:0]   row_p1;
  logic                 row_last;
  logic                 frame_last;
  logic                 accept;
  logic                 store_we;

  nnis_pkg::nnis_pix_t  wr_pix;
  nnis_pkg::nnis_pix_t  rd_pix;
  nnis_pkg::nnis_geom_t geom;
  logic [nnis_pkg::STORE_AW-1:0] rd_addr;

  assign iw_eff = (int'(in_width_r) > nnis_pkg::MAX_WIDTH) ?
                  DIM_W'(nnis_pkg::MAX_WIDTH) : in_width_r;
  assign ih_eff = (int'(in_height_r) > nnis_pkg::MAX_HEIGHT) ?
                  DIM_W'(nnis_pkg::MAX_HEIGHT) : in_height_r;
  assign ow_eff = (int'(out_width_r) > nnis_pkg::MAX_OUT_W) ?
                  OUT_DIM_W'(nnis_pkg::MAX_OUT_W) : out_width_r;
  assign oh_eff = (int'(out_height_r) > nnis_pkg::MAX_OUT_H) ?
                  OUT_DIM_W'(nnis_pkg::MAX_OUT_H) : out_height_r;
  assign total  = iw_eff * ih_eff;

  assign col_p1     = {1'b0, out_col_r} + (OUT_DIM_W + 1)'(1);
  assign row_p1     = {1'b0, out_row_r} + (OUT_DIM_W + 1)'(1);
  assign row_last   = col_p1 >= {1'b0, ow_eff};
  assign frame_last = row_last && (row_p1 >= {1'b0, oh_eff});

  assign in_pix.ready = (state_r == S_IDLE);
  assign accept       = in_pix.valid && in_pix.ready;

  assign wr_pix.red   = in_pix.red_in;
  assign wr_pix.green = in_pix.green_in;
  assign wr_pix.blue  = in_pix.blue_in;

  assign geom.iw   = iw_eff;
  assign geom.ih   = ih_eff;
  assign geom.step = step_r;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    load_cnt_nxt   = load_cnt_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_valid_nxt  = out_valid_r && !out_pix.ready;
    pos_col_nxt    = pos_col_r;
    pos_row_nxt    = pos_row_r;
    row_last_nxt   = row_last_r;
    frame_last_nxt = frame_last_r;
    empty_src_nxt  = empty_src_r;
    pad_nxt        = pad_r;
    opix_nxt       = opix_r;
    opad_nxt       = opad_r;
    orow_end_nxt   = orow_end_r;
    oframe_end_nxt = oframe_end_r;
    store_we       = 1'b0;
    lc_tmp         = load_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!phase_r) begin
            if (in_pix.cmd == nnis_pkg::CMD_LOAD) begin
              if (TOT_W'(load_cnt_r) < total) begin
                store_we = 1'b1;
                lc_tmp   = load_cnt_r + LC_W'(1);
              end
              load_cnt_nxt = lc_tmp;
              if (TOT_W'(lc_tmp) >= total) begin
                phase_nxt   = 1'b1;
                out_col_nxt = '0;
                out_row_nxt = '0;
              end
            end
          end else if (in_pix.cmd == nnis_pkg::CMD_FETCH) begin
            if (ow_eff == '0 || oh_eff == '0) begin
              // empty output: drop back to loading without a pixel
              phase_nxt    = 1'b0;
              load_cnt_nxt = '0;
              out_col_nxt  = '0;
              out_row_nxt  = '0;
            end else begin
              pos_col_nxt    = out_col_r;
              pos_row_nxt    = out_row_r;
              row_last_nxt   = row_last;
              frame_last_nxt = frame_last;
              empty_src_nxt  = (iw_eff == '0) || (ih_eff == '0);
              // (4 - 3*w % 4) % 4 reduces to w mod 4
              pad_nxt        = row_last ? ow_eff[PAD_W-1:0] : '0;
              state_nxt      = S_MUL;
              if (frame_last) begin
                phase_nxt    = 1'b0;
                load_cnt_nxt = '0;
                out_col_nxt  = '0;
                out_row_nxt  = '0;
              end else if (row_last) begin
                out_col_nxt = '0;
                out_row_nxt = row_p1[OUT_DIM_W-1:0];
              end else begin
                out_col_nxt = col_p1[OUT_DIM_W-1:0];
              end
            end
          end
        end
      end
      S_MUL:   state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_READ;
      S_READ:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_pix.ready) begin
          out_valid_nxt  = 1'b1;
          opix_nxt       = empty_src_r ? '0 : rd_pix;
          opad_nxt       = pad_r;
          orow_end_nxt   = row_last_r;
          oframe_end_nxt = frame_last_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= 1'b0;
      load_cnt_r   <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_valid_r  <= 1'b0;
      in_width_r   <= '0;
      in_height_r  <= '0;
      out_width_r  <= '0;
      out_height_r <= '0;
      step_r       <= nnis_pkg::STEP_RESET;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      load_cnt_r  <= load_cnt_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          nnis_pkg::REG_IN_WIDTH:   in_width_r   <= cfg_wdata[DIM_W-1:0];
          nnis_pkg::REG_IN_HEIGHT:  in_height_r  <= cfg_wdata[DIM_W-1:0];
          nnis_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_wdata[OUT_DIM_W-1:0];
          nnis_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_wdata[OUT_DIM_W-1:0];
          nnis_pkg::REG_STEP_Q16:   step_r       <= cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_col_r    <= pos_col_nxt;
    pos_row_r    <= pos_row_nxt;
    row_last_r   <= row_last_nxt;
    frame_last_r <= frame_last_nxt;
    empty_src_r  <= empty_src_nxt;
    pad_r        <= pad_nxt;
    opix_r       <= opix_nxt;
    opad_r       <= opad_nxt;
    orow_end_r   <= orow_end_nxt;
    oframe_end_r <= oframe_end_nxt;
  end

  nnis_coord u_coord (
    .clk  (clk),
    .geom (geom),
    .col  (pos_col_r),
    .row  (pos_row_r),
    .addr (rd_addr)
  );

  nnis_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (load_cnt_r[nnis_pkg::STORE_AW-1:0]),
    .wdata (wr_pix),
    .re    (state_r == S_READ),
    .raddr (rd_addr),
    .rdata (rd_pix)
  );

  assign out_pix.valid     = out_valid_r;
  assign out_pix.blue_out  = opix_r.blue;
  assign out_pix.green_out = opix_r.green;
  assign out_pix.red_out   = opix_r.red;
  assign out_pix.pad_bytes = opad_r;
  assign out_pix.row_end   = orow_end_r;
  assign out_pix.frame_end = oframe_end_r;

endmodule

[rtl/nnis_store.sv]
// Frame store: one write port, one read port with registered read data.
module nnis_store (
  input  logic                            clk,
  input  logic                            we,
  input  logic [nnis_pkg::STORE_AW-1:0]   waddr,
  input  nnis_pkg::nnis_pix_t             wdata,
  input  logic                            re,
  input  logic [nnis_pkg::STORE_AW-1:0]   raddr,
  output nnis_pkg::nnis_pix_t             rdata
);

  nnis_pkg::nnis_pix_t mem [nnis_pkg::STORE_DEPTH];
  nnis_pkg::nnis_pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/nnis_coord.sv]
// Source coordinate path: Q16.16 multiply, clamp, then raster address.
module nnis_coord (
  input  logic                              clk,
  input  nnis_pkg::nnis_geom_t              geom,
  input  logic [nnis_pkg::OUT_DIM_W-1:0]    col,
  input  logic [nnis_pkg::OUT_DIM_W-1:0]    row,
  output logic [nnis_pkg::STORE_AW-1:0]     addr
);

  localparam int PROD_W  = nnis_pkg::PROD_W;
  localparam int COORD_W = nnis_pkg::COORD_W;
  localparam int FRAC_W  = nnis_pkg::FRAC_W;
  localparam int DIM_W   = nnis_pkg::DIM_W;
  localparam int X_W     = nnis_pkg::X_W;
  localparam int Y_W     = nnis_pkg::Y_W;
  localparam int BASE_W  = Y_W + DIM_W;

  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;
  logic [PROD_W-1:0]  prod_x_r;
  logic [PROD_W-1:0]  prod_y_r;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [DIM_W-1:0]   lim_x;
  logic [DIM_W-1:0]   lim_y;
  logic [X_W-1:0]     x_nxt;
  logic [Y_W-1:0]     y_nxt;
  logic [X_W-1:0]     x_r;
  logic [Y_W-1:0]     y_r;
  logic [BASE_W-1:0]  row_base;
  logic [BASE_W:0]    addr_sum;

  assign prod_x = col * geom.step;
  assign prod_y = row * geom.step;

  always_ff @(posedge clk) begin
    prod_x_r <= prod_x;
    prod_y_r <= prod_y;
  end

  // floor, then clamp to the last source column/row
  assign cx    = prod_x_r[PROD_W-1:FRAC_W];
  assign cy    = prod_y_r[PROD_W-1:FRAC_W];
  assign lim_x = geom.iw - DIM_W'(1);
  assign lim_y = geom.ih - DIM_W'(1);

  always_comb begin
    if (geom.iw == '0) begin
      x_nxt = '0;
    end else if (cx > COORD_W'(lim_x)) begin
      x_nxt = X_W'(lim_x);
    end else begin
      x_nxt = cx[X_W-1:0];
    end
    if (geom.ih == '0) begin
      y_nxt = '0;
    end else if (cy > COORD_W'(lim_y)) begin
      y_nxt = Y_W'(lim_y);
    end else begin
      y_nxt = cy[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign row_base = y_r * geom.iw;
  assign addr_sum = {1'b0, row_base} + (BASE_W + 1)'(x_r);
  assign addr     = addr_sum[nnis_pkg::STORE_AW-1:0];

endmodule

[rtl/nnis_checker.sv]
// Port-level checks of the scaler output channel, bound to the top level.
module nnis_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_blue,
  input logic [1:0] out_pad,
  input logic       out_row_end,
  input logic       out_frame_end
);

  // hold a stalled transfer
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_blue) && $stable(out_pad) &&
    $stable(out_row_end) && $stable(out_frame_end))
    else $error("out payload changed while stalled");

  a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  a_pad_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_end |-> out_pad == 2'd0)
    else $error("padding off a row end");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

endmodule

bind nearest_neighbor_image_scaler_core nnis_checker u_nnis_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_pix.valid),
  .out_ready     (out_pix.ready),
  .out_blue      (out_pix.blue_out),
  .out_pad       (out_pix.pad_bytes),
  .out_row_end   (out_pix.row_end),
  .out_frame_end (out_pix.frame_end)
);
